// ===== src/gmb_pkg.sv =====
// shared types and constants for the grid maze breadth-first solver
package gmb_pkg;

	localparam int unsigned DIM_W  = 7;
	localparam int unsigned COL_W  = 6;
	localparam int unsigned CODE_W = 2;
	localparam int unsigned VIS_W  = 15;
	localparam int unsigned LEN_W  = 12;

	localparam logic [CODE_W-1:0] CODE_WALL  = 2'd0;
	localparam logic [CODE_W-1:0] CODE_START = 2'd2;
	localparam logic [CODE_W-1:0] CODE_END   = 2'd3;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN  = 1'b1;

	localparam logic [DIM_W-1:0] DIM_MAX   = 7'd64;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
	localparam logic [VIS_W-1:0] VIS_SAT   = 15'd32767;
	localparam logic [LEN_W-1:0] LEN_SAT   = 12'd4095;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CODE_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [VIS_W-1:0] visited_count;
		logic [LEN_W-1:0] path_length;
		logic             reached;
	} result_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = 7'd1;
		else if (v > DIM_MAX) r = DIM_MAX;
		return r;
	endfunction

endpackage

// ===== src/gmb_ram.sv =====
// generic simple dual-port ram with registered read
module gmb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gmb_front.sv =====
// input side: accepts transactions into a short command queue
module gmb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  gmb_pkg::cmd_t cmd_in,
	output logic          cmd_valid,
	output gmb_pkg::cmd_t cmd_out,
	input  logic          cmd_take
);
	import gmb_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_out   = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/gmb_back.sv =====
// execution side: grid loading, breadth-first search and path walk
module gmb_back #(
	parameter int unsigned MAX_CELLS   = 4096,
	parameter int unsigned QUEUE_DEPTH = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  gmb_pkg::cmd_t               cmd,
	output logic                        cmd_take,
	input  logic [gmb_pkg::DIM_W-1:0]   grid_width,
	input  logic [gmb_pkg::DIM_W-1:0]   grid_height,
	output logic                        res_valid,
	output gmb_pkg::result_t            res,
	input  logic                        res_take
);
	import gmb_pkg::*;

	localparam int unsigned AW  = $clog2(MAX_CELLS);
	localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW  = ($clog2(MAX_CELLS + 1) > 13) ? $clog2(MAX_CELLS + 1) : 13;
	localparam int unsigned XW  = NW + 1;
	localparam int unsigned BW  = $clog2(AW);
	localparam int unsigned EW  = AW + COL_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_CLEAR, S_SEED, S_POP, S_CUR, S_NB, S_NBW, S_PREQ, S_PWAIT, S_OUT
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    lp_q, start_q, end_q, cur_q, nb_q, last_q, div_q;
	logic [COL_W-1:0] col_q, nbcol_q;
	logic [DIM_W-1:0] wc_q, rem_q;
	logic [NW-1:0]    n_q, clr_q;
	logic [BW-1:0]    bit_q;
	logic [QW:0]      head_q, tail_q;
	logic [1:0]       k_q;
	logic [VIS_W-1:0] count_q;
	logic [LEN_W-1:0] len_q;
	logic [AW:0]      guard_q;
	logic             reached_q;
	result_t          res_q;
	logic             res_valid_q;

	logic [CODE_W-1:0] grid_rd;
	logic              vis_rd;
	logic [AW-1:0]     pred_rd;
	logic [EW-1:0]     q_rd;

	logic              grid_we, vis_we, vis_wd, pred_we, q_we;
	logic [AW-1:0]     grid_wa, vis_wa, pred_wa, pred_wd, nb_c;
	logic [QW-1:0]     q_wa;
	logic [EW-1:0]     q_wd;
	logic              nb_ok;
	logic [COL_W-1:0]  nbcol_c;
	logic [XW-1:0]     cur_x, w_x, n_x, nb_x;
	logic [12:0]       prod;
	logic [NW-1:0]     n_c;
	logic [DIM_W:0]    rem_t;
	logic [AW-1:0]     q_cell;
	logic              push_ok;

	assign cur_x  = XW'(cur_q);
	assign w_x    = XW'(wc_q);
	assign n_x    = XW'(n_q);
	assign q_cell = q_rd[EW-1:COL_W];
	assign prod   = 13'(clamp_dim(grid_width)) * 13'(clamp_dim(grid_height));
	assign n_c    = (NW'(prod) > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : NW'(prod);
	assign rem_t  = {rem_q, div_q[AW-1]};
	assign push_ok = (grid_rd != CODE_WALL) && !vis_rd && (tail_q < (QW+1)'(QUEUE_DEPTH));

	always_comb begin
		nb_ok   = 1'b0;
		nb_x    = cur_x;
		nbcol_c = col_q;
		case (k_q)
			2'd0: begin
				nb_ok = (cur_x >= w_x);
				nb_x  = cur_x - w_x;
			end
			2'd1: begin
				nb_ok   = ((DIM_W'(col_q) + 7'd1) != wc_q) && ((cur_x + XW'(1)) < n_x);
				nb_x    = cur_x + XW'(1);
				nbcol_c = col_q + 6'd1;
			end
			2'd2: begin
				nb_ok = ((cur_x + w_x) < n_x);
				nb_x  = cur_x + w_x;
			end
			default: begin
				nb_ok   = (col_q != '0);
				nb_x    = cur_x - XW'(1);
				nbcol_c = col_q - 6'd1;
			end
		endcase
		nb_c = nb_x[AW-1:0];
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign grid_we  = cmd_take && (cmd.action == ACT_LOAD);
	assign grid_wa  = lp_q;
	assign vis_we   = (state_q == S_CLEAR) || ((state_q == S_CUR) && (q_cell != end_q));
	assign vis_wa   = (state_q == S_CLEAR) ? clr_q[AW-1:0] : q_cell;
	assign vis_wd   = (state_q != S_CLEAR);
	assign pred_we  = ((state_q == S_SEED) && (NW'(start_q) < n_q)) ||
	                  ((state_q == S_NBW) && push_ok);
	assign pred_wa  = (state_q == S_SEED) ? start_q : nb_q;
	assign pred_wd  = (state_q == S_SEED) ? start_q : cur_q;
	assign q_we     = pred_we;
	assign q_wa     = tail_q[QW-1:0];
	assign q_wd     = (state_q == S_SEED) ? {start_q, rem_q[COL_W-1:0]} : {nb_q, nbcol_q};

	gmb_ram #(.WIDTH(CODE_W), .DEPTH(MAX_CELLS)) u_grid (
		.clk(clk), .we(grid_we), .waddr(grid_wa), .wdata(cmd.code),
		.raddr(nb_c), .rdata(grid_rd)
	);
	gmb_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
		.raddr(nb_c), .rdata(vis_rd)
	);
	gmb_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
		.raddr(last_q), .rdata(pred_rd)
	);
	gmb_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.raddr(head_q[QW-1:0]), .rdata(q_rd)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lp_q        <= '0;
			start_q     <= '0;
			end_q       <= '0;
			cur_q       <= '0;
			nb_q        <= '0;
			last_q      <= '0;
			div_q       <= '0;
			col_q       <= '0;
			nbcol_q     <= '0;
			wc_q        <= 7'd1;
			rem_q       <= '0;
			n_q         <= '0;
			clr_q       <= '0;
			bit_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			count_q     <= '0;
			len_q       <= '0;
			guard_q     <= '0;
			reached_q   <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_take && res_valid_q) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						if (cmd.action == ACT_LOAD) begin
							if (cmd.code == CODE_START) start_q <= lp_q;
							if (cmd.code == CODE_END) end_q <= lp_q;
							lp_q <= (lp_q == AW'(MAX_CELLS - 1)) ? '0 : lp_q + AW'(1);
						end else begin
							lp_q      <= '0;
							wc_q      <= clamp_dim(grid_width);
							n_q       <= n_c;
							div_q     <= start_q;
							rem_q     <= '0;
							bit_q     <= BW'(AW - 1);
							clr_q     <= '0;
							head_q    <= '0;
							tail_q    <= '0;
							count_q   <= '0;
							len_q     <= '0;
							reached_q <= 1'b0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= (rem_t >= {1'b0, wc_q}) ? DIM_W'(rem_t - {1'b0, wc_q}) : DIM_W'(rem_t);
					div_q <= div_q << 1;
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == n_q - NW'(1)) state_q <= S_SEED;
				end
				S_SEED: begin
					if (NW'(start_q) < n_q) begin
						tail_q  <= (QW+1)'(1);
						state_q <= S_POP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_OUT;
					end else begin
						head_q  <= head_q + (QW+1)'(1);
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					cur_q <= q_cell;
					col_q <= q_rd[COL_W-1:0];
					k_q   <= 2'd0;
					if (q_cell == end_q) begin
						reached_q <= 1'b1;
						last_q    <= end_q;
						guard_q   <= '0;
						state_q   <= S_PREQ;
					end else begin
						if (count_q != VIS_SAT) count_q <= count_q + VIS_W'(1);
						state_q <= S_NB;
					end
				end
				S_NB: begin
					nb_q    <= nb_c;
					nbcol_q <= nbcol_c;
					if (nb_ok) begin
						state_q <= S_NBW;
					end else if (k_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NBW: begin
					if (push_ok) tail_q <= tail_q + (QW+1)'(1);
					if (k_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_NB;
					end
				end
				S_PREQ: begin
					if ((last_q == start_q) || (guard_q >= (AW+1)'(MAX_CELLS))) state_q <= S_OUT;
					else state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					last_q  <= pred_rd;
					guard_q <= guard_q + (AW+1)'(1);
					if (len_q != LEN_SAT) len_q <= len_q + LEN_W'(1);
					state_q <= S_PREQ;
				end
				S_OUT: begin
					if (!res_valid_q) begin
						res_q.visited_count <= count_q;
						res_q.path_length   <= len_q;
						res_q.reached       <= reached_q;
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/grid_maze_bfs_solver.sv =====
// top level of the grid maze breadth-first solver
// A load transaction (action 0) enters a two-entry command queue and writes the next cell in
// row-major order once the execution side takes it; back-to-back loads stream at one per cycle
// while no run is in progress. A run transaction (action 1) finds the start column, clears
// the visited map over n cells (n = width * height, at most MAX_CELLS), then pops the search
// queue and checks the four neighbors of each popped cell, then walks the path back to the
// start; each cell memory has a single read port.
// One result comes out per run, none per load; results wait in an output register.
module grid_maze_bfs_solver #(
	parameter int unsigned MAX_CELLS   = 4096,
	parameter int unsigned QUEUE_DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [1:0]  cell_code,
	output logic        empty,
	input  logic        pop,
	output logic [14:0] visited_count,
	output logic [11:0] path_length,
	output logic        reached,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gmb_pkg::*;

	cmd_t             cmd_in, cmd_out;
	logic             cmd_valid, cmd_take, res_valid;
	result_t          res;
	logic [DIM_W-1:0] width_q, height_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_HEIGHT) height_q <= pwdata[DIM_W-1:0];
			else width_q <= pwdata[DIM_W-1:0];
		end
	end

	assign cmd_in.action = action;
	assign cmd_in.code   = cell_code;

	gmb_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cmd_in),
		.cmd_valid(cmd_valid), .cmd_out(cmd_out), .cmd_take(cmd_take)
	);

	gmb_back #(.MAX_CELLS(MAX_CELLS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd_out),
		.cmd_take(cmd_take), .grid_width(width_q), .grid_height(height_q),
		.res_valid(res_valid), .res(res), .res_take(pop)
	);

	assign empty         = !res_valid;
	assign visited_count = res.visited_count;
	assign path_length   = res.path_length;
	assign reached       = res.reached;

endmodule

// ===== src/gmb_checker.sv =====
// port-level checks for the grid maze breadth-first solver
module gmb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  logic        pop,
	input  logic [14:0] visited_count,
	input  logic [11:0] path_length,
	input  logic        reached,
	input  logic        pready
);

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(visited_count) && $stable(path_length)
		&& $stable(reached)))
		else $error("result changed while waiting");

	a_path: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !reached) |-> (path_length == 12'd0))
		else $error("path length without reaching end");

	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result not consumed after pop");

endmodule

bind grid_maze_bfs_solver gmb_checker u_gmb_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.visited_count(visited_count), .path_length(path_length),
	.reached(reached), .pready(pready)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for the grid maze breadth-first solver
`timescale 1ns / 1ps
module tb_top;
	import gmb_pkg::*;

	localparam int NCELL     = 4096;
	localparam int QDEPTH    = 16384;
	localparam int WDOG_MAX  = 1000000;
	localparam int HOLD_LEN  = 400;
	localparam int ITEM_GOAL = 1800;
	localparam int WIDE_N    = 1024;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        action;
	logic [1:0]  cell_code;
	logic        empty;
	logic        pop;
	logic [14:0] visited_count;
	logic [11:0] path_length;
	logic        reached;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	grid_maze_bfs_solver dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.cell_code(cell_code), .empty(empty), .pop(pop), .visited_count(visited_count),
		.path_length(path_length), .reached(reached), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// solver mirror
	logic [1:0]  maze_code [NCELL];
	bit          seen_cell [NCELL];
	int          came_from [NCELL];
	int          bfs_fifo [QDEPTH];
	int          fifo_tail;
	int          load_ptr;
	int          start_idx;
	int          end_idx;
	logic [6:0]  width_reg;
	logic [6:0]  height_reg;

	cmd_t        cmd_q[$];
	result_t     solution_q[$];
	int          errors;
	int          items_sent;
	bit          holding_cmd;
	bit          steady;
	int          stall_req;
	int          stall_seen;
	int          quiet_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int fit_dim(logic [6:0] v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return v;
	endfunction

	function automatic void offer_cell(int c, int from);
		if (maze_code[c] == CODE_WALL || seen_cell[c]) return;
		if (fifo_tail >= QDEPTH) return;
		came_from[c] = from;
		bfs_fifo[fifo_tail] = c;
		fifo_tail++;
	endfunction

	function automatic result_t solve_maze();
		result_t r;
		int w, n, head, cur, cnt, len, last, guard;
		bit hit;
		w = fit_dim(width_reg);
		n = w * fit_dim(height_reg);
		if (n > NCELL) n = NCELL;
		foreach (seen_cell[i]) seen_cell[i] = 0;
		head = 0;
		fifo_tail = 0;
		load_ptr = 0;
		cnt = 0;
		len = 0;
		hit = 0;
		if (start_idx < n) begin
			came_from[start_idx] = start_idx;
			bfs_fifo[fifo_tail++] = start_idx;
			while (head < fifo_tail) begin
				cur = bfs_fifo[head++];
				if (cur == end_idx) begin
					hit = 1;
					break;
				end
				seen_cell[cur] = 1;
				if (cnt < 32767) cnt++;
				if (cur >= w) offer_cell(cur - w, cur);
				if ((cur + 1) % w != 0 && cur + 1 < n) offer_cell(cur + 1, cur);
				if (cur + w < n) offer_cell(cur + w, cur);
				if (cur % w != 0) offer_cell(cur - 1, cur);
			end
			if (hit) begin
				last = end_idx;
				guard = 0;
				while (last != start_idx && guard < NCELL) begin
					last = came_from[last % NCELL];
					guard++;
					if (len < 4095) len++;
				end
			end
		end
		r.visited_count = 15'(cnt);
		r.path_length = 12'(len);
		r.reached = hit;
		return r;
	endfunction

	function automatic void apply_cmd(cmd_t c);
		if (c.action == ACT_LOAD) begin
			maze_code[load_ptr] = c.code;
			if (c.code == CODE_START) start_idx = load_ptr;
			if (c.code == CODE_END) end_idx = load_ptr;
			load_ptr = (load_ptr + 1) % NCELL;
		end else begin
			solution_q = {solution_q, solve_maze()};
		end
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver
	cmd_t cur_cmd;
	int   send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= ACT_LOAD;
			cell_code <= CODE_WALL;
			holding_cmd = 0;
			send_gap = 0;
		end else begin
			if (push && !full) begin
				apply_cmd(cur_cmd);
				holding_cmd = 0;
			end
			if (!holding_cmd && cmd_q.size() > 0) begin
				cur_cmd = cmd_q.pop_front();
				send_gap = steady ? 0 : $urandom_range(0, 7);
				holding_cmd = 1;
			end
			if (holding_cmd && send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (holding_cmd) begin
				push <= 1'b1;
				action <= cur_cmd.action;
				cell_code <= cur_cmd.code;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	int      pop_gap;
	int      hold_left;
	result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
			hold_left = 0;
			stall_seen = 0;
		end else begin
			if (pop && !empty) begin
				if (solution_q.size() == 0) begin
					report("unexpected transaction", 1, 0);
				end else begin
					want = solution_q.pop_front();
					if (visited_count !== want.visited_count)
						report("visited_count", visited_count, want.visited_count);
					if (path_length !== want.path_length)
						report("path_length", path_length, want.path_length);
					if (reached !== want.reached)
						report("reached", reached, want.reached);
				end
				pop_gap = steady ? 0 : $urandom_range(0, 7);
			end
			if (stall_req != stall_seen) begin
				stall_seen = stall_req;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("[grid_maze_bfs_solver] ERROR");
			$finish;
		end
	end

	task automatic wait_drain();
		while (cmd_q.size() > 0 || holding_cmd || solution_q.size() > 0 || push)
			@(posedge clk);
	endtask

	task automatic cfg_write(bit idx, logic [6:0] val);
		wait_drain();
		repeat (10) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & 32'hffff_ff80) | 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH) width_reg = val;
		else width_reg = width_reg;
		if (idx == REG_HEIGHT) height_reg = val;
	endtask

	task automatic add_cmd(logic act, logic [1:0] code);
		cmd_t c;
		c.action = act;
		c.code = code;
		cmd_q = {cmd_q, c};
		items_sent++;
	endtask

	task automatic add_loads(int cnt, int wall_pct);
		logic [1:0] c;
		int p;
		for (int i = 0; i < cnt; i++) begin
			p = $urandom_range(0, 99);
			if (p < wall_pct) c = CODE_WALL;
			else if (p > 97) c = 2'($urandom_range(2, 3));
			else c = 2'd1;
			add_cmd(ACT_LOAD, c);
		end
	endtask

	// full maze: random cells, usually with a start and an end dropped in at random spots
	task automatic add_maze(int n, int wall_pct);
		logic [1:0] cells[$];
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			cells = {cells, (p < wall_pct ? CODE_WALL :
				(p > 97 ? 2'($urandom_range(0, 3)) : 2'd1))};
		end
		if ($urandom_range(0, 9) != 0) cells[$urandom_range(0, n - 1)] = CODE_START;
		if ($urandom_range(0, 9) != 0) cells[$urandom_range(0, n - 1)] = CODE_END;
		foreach (cells[i]) add_cmd(ACT_LOAD, cells[i]);
	endtask

	int gw, gh, n, wall;
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		items_sent = 0;
		steady = 0;
		stall_req = 0;
		quiet_cycles = 0;
		load_ptr = 0;
		start_idx = 0;
		end_idx = 0;
		width_reg = DIM_RESET;
		height_reg = DIM_RESET;
		fifo_tail = 0;
		foreach (maze_code[i]) maze_code[i] = CODE_WALL;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cell: start equals end
		cfg_write(REG_WIDTH, 7'd1);
		cfg_write(REG_HEIGHT, 7'd1);
		add_cmd(ACT_LOAD, CODE_START);
		add_cmd(ACT_RUN, 2'd3);
		add_cmd(ACT_LOAD, CODE_END);
		add_cmd(ACT_RUN, 2'd0);
		// 2x2 mazes: reachable, start on a wall, unreachable end, start outside grid
		cfg_write(REG_WIDTH, 7'd2);
		cfg_write(REG_HEIGHT, 7'd2);
		add_cmd(ACT_LOAD, CODE_START); add_cmd(ACT_LOAD, 2'd1);
		add_cmd(ACT_LOAD, CODE_WALL); add_cmd(ACT_LOAD, CODE_END);
		add_cmd(ACT_RUN, 2'd1);
		add_cmd(ACT_LOAD, CODE_WALL); add_cmd(ACT_LOAD, 2'd1);
		add_cmd(ACT_LOAD, 2'd1); add_cmd(ACT_LOAD, CODE_END);
		add_cmd(ACT_RUN, 2'd2);
		add_cmd(ACT_LOAD, CODE_START); add_cmd(ACT_LOAD, CODE_WALL);
		add_cmd(ACT_LOAD, CODE_WALL); add_cmd(ACT_LOAD, CODE_END);
		add_cmd(ACT_RUN, 2'd0);
		add_cmd(ACT_LOAD, 2'd1); add_cmd(ACT_LOAD, 2'd1);
		add_cmd(ACT_LOAD, 2'd1); add_cmd(ACT_LOAD, CODE_END);
		add_cmd(ACT_LOAD, CODE_START);
		add_cmd(ACT_RUN, 2'd3);

		// wide grid through saturating values
		cfg_write(REG_WIDTH, 7'd127);
		cfg_write(REG_HEIGHT, 7'd0);
		cfg_write(REG_HEIGHT, 7'd16);
		add_loads(WIDE_N, 15);
		cmd_q[0].code = CODE_START;
		cmd_q[WIDE_N - 1].code = CODE_END;
		add_cmd(ACT_RUN, 2'd0);

		// long output stall while runs keep coming
		cfg_write(REG_WIDTH, 7'd3);
		cfg_write(REG_HEIGHT, 7'd3);
		add_maze(9, 20);
		stall_req++;
		for (int i = 0; i < 12; i++) add_cmd(ACT_RUN, 2'($urandom_range(0, 3)));
		wait_drain();

		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 15) == 0) begin
				gw = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
				gh = 1;
			end else begin
				gw = $urandom_range(1, 7);
				gh = $urandom_range(1, 7);
			end
			steady = ($urandom_range(0, 3) == 0);
			cfg_write(REG_WIDTH, 7'(gw));
			cfg_write(REG_HEIGHT, 7'(gh));
			n = fit_dim(7'(gw)) * fit_dim(7'(gh));
			for (int m = $urandom_range(1, 4); m > 0; m--) begin
				wall = $urandom_range(0, 45);
				if ($urandom_range(0, 9) == 0) begin
					for (int i = 0; i < n; i++) add_cmd(ACT_LOAD, 2'($urandom_range(0, 3)));
				end else begin
					add_maze(n, wall);
				end
				if ($urandom_range(0, 9) == 0) begin
					add_loads($urandom_range(0, 2), wall);
					add_cmd(ACT_LOAD, CODE_START);
				end
				add_cmd(ACT_RUN, 2'($urandom_range(0, 3)));
				if ($urandom_range(0, 4) == 0) add_cmd(ACT_RUN, 2'($urandom_range(0, 3)));
			end
		end

		wait_drain();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("[grid_maze_bfs_solver] OK");
		end else begin
			$display("[grid_maze_bfs_solver] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/gmb_pkg.sv
src/gmb_ram.sv
src/gmb_front.sv
src/gmb_back.sv
src/grid_maze_bfs_solver.sv
src/gmb_checker.sv
verif/tb_top.sv
